// ===== design/tkrt_pkg.sv =====
// ----------------------------------------------------------------------------
// tkrt_pkg
// Types, codes and defaults shared by the keyed record table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tkrt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned OUT_CNT_W = 5;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_UPSERT = 2'd1;
  localparam logic [1:0] OP_EVICT  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key_digest;
    logic [31:0] key_namespace;
    logic        entry_state;
    logic [7:0]  entry_result;
    logic [63:0] created_time;
    logic [63:0] time_to_live;
    logic [63:0] now_time;
  } req_t;

  typedef struct packed {
    logic                 status;
    logic                 found;
    logic                 found_state;
    logic [7:0]           found_result;
    logic [63:0]          found_created;
    logic [63:0]          found_ttl;
    logic [OUT_CNT_W-1:0] evicted_count;
    logic [OUT_CNT_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [63:0] key_digest;
    logic [31:0] key_namespace;
    logic        state;
    logic [7:0]  result;
    logic [63:0] created;
    logic [63:0] ttl;
  } rec_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic rd_last;
    logic inc;
    logic move;
    logic ups_hit;
    logic ups_miss;
    logic fin;
    logic fin_found;
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic key_match;
    logic expired;
    logic is_upsert;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_EV_READ,
    ST_EV_CHECK,
    ST_EV_MOVE
  } state_e;

endpackage

`default_nettype wire

// ===== design/tkrt_ram.sv =====
// ----------------------------------------------------------------------------
// tkrt_ram
// Generic RAM with one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tkrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/tkrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkrt_ctrl
// Sequencer that walks the record table for lookup, upsert and evict.
// ----------------------------------------------------------------------------
`default_nettype none

module tkrt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic [1:0]    op_i,
  input  tkrt_pkg::sts_t     sts_i,
  output tkrt_pkg::cmd_t     cmd_o,
  output logic               busy
);

  tkrt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tkrt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != tkrt_pkg::ST_IDLE);
    unique case (state_q)
      tkrt_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (op_i == tkrt_pkg::OP_LOOKUP || op_i == tkrt_pkg::OP_UPSERT) begin
            state_d = tkrt_pkg::ST_READ;
          end else if (op_i == tkrt_pkg::OP_EVICT) begin
            state_d = tkrt_pkg::ST_EV_READ;
          end else begin
            cmd_o.fin = 1'b1;
          end
        end
      end
      tkrt_pkg::ST_READ: begin
        if (sts_i.idx_end) begin
          cmd_o.ups_miss = sts_i.is_upsert;
          cmd_o.fin      = 1'b1;
          state_d        = tkrt_pkg::ST_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = tkrt_pkg::ST_CHECK;
        end
      end
      tkrt_pkg::ST_CHECK: begin
        if (sts_i.key_match) begin
          cmd_o.ups_hit   = sts_i.is_upsert;
          cmd_o.fin_found = ~sts_i.is_upsert;
          cmd_o.fin       = 1'b1;
          state_d         = tkrt_pkg::ST_IDLE;
        end else begin
          cmd_o.inc = 1'b1;
          state_d   = tkrt_pkg::ST_READ;
        end
      end
      tkrt_pkg::ST_EV_READ: begin
        if (sts_i.idx_end) begin
          cmd_o.fin = 1'b1;
          state_d   = tkrt_pkg::ST_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = tkrt_pkg::ST_EV_CHECK;
        end
      end
      tkrt_pkg::ST_EV_CHECK: begin
        if (sts_i.expired) begin
          cmd_o.rd_last = 1'b1;
          state_d       = tkrt_pkg::ST_EV_MOVE;
        end else begin
          cmd_o.inc = 1'b1;
          state_d   = tkrt_pkg::ST_EV_READ;
        end
      end
      tkrt_pkg::ST_EV_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = tkrt_pkg::ST_EV_READ;
      end
      default: begin
        state_d = tkrt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/tkrt_dp.sv =====
// ----------------------------------------------------------------------------
// tkrt_dp
// Datapath: request register, scan index, record count, record RAM, key
// compare, expiry check and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tkrt_dp #(
  parameter int unsigned Capacity = tkrt_pkg::CAPACITY_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  tkrt_pkg::req_t      req_i,
  input  tkrt_pkg::cmd_t      cmd_i,
  output tkrt_pkg::sts_t      sts_o,
  output tkrt_pkg::rsp_t      rsp_o,
  output logic                done_o
);

  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW = $clog2(Capacity + 1);

  tkrt_pkg::req_t req_q;
  tkrt_pkg::rsp_t rsp_q, rsp_d;
  tkrt_pkg::rec_t rdata, wdata, new_rec;
  logic           done_q;
  logic [CntW-1:0] idx_q, idx_d, cnt_q, cnt_d, removed_q, removed_d, last_cnt;
  logic [IdxW-1:0] raddr, waddr;
  logic            re, we, full;
  logic [63:0]     expiry;

  assign last_cnt = cnt_q - CntW'(1);
  assign full     = (cnt_q >= CntW'(Capacity));
  assign expiry   = rdata.created + rdata.ttl;

  assign new_rec.key_digest    = req_q.key_digest;
  assign new_rec.key_namespace = req_q.key_namespace;
  assign new_rec.state         = req_q.entry_state;
  assign new_rec.result        = req_q.entry_result;
  assign new_rec.created       = req_q.created_time;
  assign new_rec.ttl           = req_q.time_to_live;

  assign re    = cmd_i.rd | cmd_i.rd_last;
  assign raddr = cmd_i.rd_last ? last_cnt[IdxW-1:0] : idx_q[IdxW-1:0];
  assign we    = cmd_i.move | cmd_i.ups_hit | (cmd_i.ups_miss & ~full);
  assign waddr = cmd_i.ups_miss ? cnt_q[IdxW-1:0] : idx_q[IdxW-1:0];
  assign wdata = cmd_i.move ? rdata : new_rec;

  tkrt_ram #(
    .Width ($bits(tkrt_pkg::rec_t)),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sts_o.idx_end   = (idx_q >= cnt_q);
  assign sts_o.key_match = (rdata.key_digest == req_q.key_digest) &&
                           (rdata.key_namespace == req_q.key_namespace);
  assign sts_o.expired   = (rdata.ttl != 64'd0) && (req_q.now_time >= expiry);
  assign sts_o.is_upsert = (req_q.op == tkrt_pkg::OP_UPSERT);

  always_comb begin
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    removed_d = removed_q;
    if (cmd_i.load) begin
      idx_d     = '0;
      removed_d = '0;
    end
    if (cmd_i.inc) begin
      idx_d = idx_q + CntW'(1);
    end
    if (cmd_i.move) begin
      cnt_d     = last_cnt;
      removed_d = removed_q + CntW'(1);
    end
    if (cmd_i.ups_miss && !full) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_comb begin
    rsp_d               = '0;
    rsp_d.status        = cmd_i.ups_miss & full;
    rsp_d.evicted_count = cmd_i.load ? '0 : tkrt_pkg::OUT_CNT_W'(removed_q);
    rsp_d.occupancy     = tkrt_pkg::OUT_CNT_W'(cnt_d);
    if (cmd_i.fin_found) begin
      rsp_d.found         = 1'b1;
      rsp_d.found_state   = rdata.state;
      rsp_d.found_result  = rdata.result;
      rsp_d.found_created = rdata.created;
      rsp_d.found_ttl     = rdata.ttl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cnt_q     <= '0;
      removed_q <= '0;
      done_q    <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      removed_q <= removed_d;
      done_q    <= cmd_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.fin) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== design/ttl_keyed_record_table.sv =====
// ----------------------------------------------------------------------------
// ttl_keyed_record_table
// Fixed-capacity table of keyed records with lookup, upsert and expiry.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on rsp_o for exactly one cycle with done_o high, in the cycle after the
// last step of the request, and must be taken then since the block cannot be
// stalled; a new request may already be taken in that cycle. Records live in
// a single RAM with one read port and registered read data, and that port
// sets the rate. A lookup or upsert reads the stored records in turn, checks
// each key and stops at the first match or after the last record; an upsert
// then rewrites the matching record, or appends a new one if the table is not
// full. An evict checks each record for expiry and moves the last record into
// the place of an expired one, which is then checked again. An unused op
// finishes in the cycle in which it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ttl_keyed_record_table #(
  parameter int unsigned Capacity = tkrt_pkg::CAPACITY_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  tkrt_pkg::req_t req_i,
  output tkrt_pkg::rsp_t rsp_o,
  output logic           done_o
);

  tkrt_pkg::cmd_t cmd;
  tkrt_pkg::sts_t sts;

  tkrt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (req_i.op),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  tkrt_dp #(
    .Capacity (Capacity)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule

`default_nettype wire
